// ----- rtl/core/gmw_pkg.sv -----
// Shared types, constants and helpers for the grid maze wavefront router.
// No dependencies; every other file of the block imports this package.
package gmw_pkg;

  localparam int MaxRows = 32;
  localparam int MaxCols = 32;
  localparam int RowW    = $clog2(MaxRows);
  localparam int ColW    = $clog2(MaxCols);
  localparam int DimW    = 6;
  localparam int StepW   = 11;

  localparam logic [DimW-1:0] DimMin   = 6'd3;
  localparam logic [DimW-1:0] RowsMax  = DimW'(MaxRows);
  localparam logic [DimW-1:0] ColsMax  = DimW'(MaxCols);

  // status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NO_PATH   = 2'd1;
  localparam logic [1:0] ST_TRACE_ERR = 2'd2;

  // cell classes
  localparam logic [2:0] CL_WALL     = 3'd0;
  localparam logic [2:0] CL_OPEN     = 3'd1;
  localparam logic [2:0] CL_PATH     = 3'd2;
  localparam logic [2:0] CL_ENTRANCE = 3'd3;
  localparam logic [2:0] CL_EXIT     = 3'd4;

  // register index (address bit 2)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            open;
    logic            last;
  } in_t;

  typedef struct packed {
    logic             reply_is_read;
    logic [1:0]       status;
    logic [StepW-1:0] steps;
    logic [2:0]       cell_class;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SEED,
    S_FLOOD,
    S_TSTART,
    S_TRACE,
    S_REPORT
  } state_e;

  // command broadcast to every row cell
  typedef struct packed {
    logic            clear;
    logic            seed;
    logic            flood;
    logic            mark;
    logic            clr_mark;
    logic            load;
    logic            open;
    logic [RowW-1:0] qrow;
    logic [ColW-1:0] qcol;
    logic [1:0]      tgt;     // distance mod 3 for flood writes / trace target
    logic [DimW-1:0] rows;
    logic [DimW-1:0] cols;
  } cell_cmd_t;

  typedef struct packed {
    logic       open;
    logic       reached;
    logic       mark;
    logic [1:0] dm;
  } probe_t;

  typedef struct packed {
    logic up;
    logic left;
    logic down;
    logic right;
  } nb_t;

  function automatic logic [1:0] mod3_inc(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  function automatic logic [1:0] mod3_dec(input logic [1:0] x);
    return (x == 2'd0) ? 2'd2 : x - 2'd1;
  endfunction

endpackage

// ----- rtl/core/gmw_row_cell.sv -----
// One maze row: open, reached, distance mod 3 and path mark for each column.
// Trades reached vectors with the rows above and below. Uses gmw_pkg.
module gmw_row_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [gmw_pkg::RowW-1:0]  idx_i,
  input  gmw_pkg::cell_cmd_t        cmd_i,
  input  logic [gmw_pkg::MaxCols-1:0] up_reached_i,
  input  logic [gmw_pkg::MaxCols-1:0] dn_reached_i,
  output logic [gmw_pkg::MaxCols-1:0] reached_o,
  output logic [gmw_pkg::MaxCols-1:0] top_open_o,
  output logic [gmw_pkg::MaxCols-1:0] bot_open_o,
  output gmw_pkg::probe_t           probe_o,
  output gmw_pkg::nb_t              nb_o,
  output logic                      grew_o
);
  import gmw_pkg::*;

  logic [MaxCols-1:0] open_q, open_d;
  logic [MaxCols-1:0] reached_q, reached_d;
  logic [MaxCols-1:0] dm0_q, dm0_d, dm1_q, dm1_d;
  logic [MaxCols-1:0] mark_q, mark_d;
  logic [MaxCols-1:0] colmask, grow, hit;
  logic [DimW-1:0]    idx_w;
  logic               interior, sel, is_up, is_dn;
  logic [ColW-1:0]    cl, cr;

  assign idx_w = {1'b0, idx_i};
  assign interior = (idx_i != '0) && (idx_w <= cmd_i.rows - 6'd2);
  assign sel   = (idx_i == cmd_i.qrow);
  assign is_up = (idx_w + 6'd1 == {1'b0, cmd_i.qrow});
  assign is_dn = (idx_w == {1'b0, cmd_i.qrow} + 6'd1);
  assign cl = cmd_i.qcol - ColW'(1);
  assign cr = cmd_i.qcol + ColW'(1);

  always_comb begin
    for (int c = 0; c < MaxCols; c++) begin
      colmask[c] = (DimW'(c) < cmd_i.cols);
      hit[c]     = reached_q[c] && ({dm1_q[c], dm0_q[c]} == cmd_i.tgt);
    end
  end

  assign grow = (cmd_i.flood && interior) ?
                (open_q & ~reached_q & colmask &
                 (up_reached_i | dn_reached_i | (reached_q << 1) | (reached_q >> 1))) : '0;

  always_comb begin
    open_d    = open_q;
    reached_d = reached_q;
    dm0_d     = dm0_q;
    dm1_d     = dm1_q;
    mark_d    = mark_q;
    if (cmd_i.load && sel) open_d[cmd_i.qcol] = cmd_i.open;
    if (cmd_i.clear) begin
      reached_d = '0;
      mark_d    = '0;
    end
    if (cmd_i.seed && sel) begin
      reached_d[cmd_i.qcol] = 1'b1;
      dm0_d[cmd_i.qcol]     = 1'b0;
      dm1_d[cmd_i.qcol]     = 1'b1;
    end
    if (cmd_i.flood) begin
      reached_d = reached_q | grow;
      dm0_d = (dm0_q & ~grow) | (grow & {MaxCols{cmd_i.tgt[0]}});
      dm1_d = (dm1_q & ~grow) | (grow & {MaxCols{cmd_i.tgt[1]}});
    end
    if (cmd_i.mark && sel) mark_d[cmd_i.qcol] = 1'b1;
    if (cmd_i.clr_mark) mark_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= '0;
      reached_q <= '0;
      dm0_q     <= '0;
      dm1_q     <= '0;
      mark_q    <= '0;
    end else begin
      open_q    <= open_d;
      reached_q <= reached_d;
      dm0_q     <= dm0_d;
      dm1_q     <= dm1_d;
      mark_q    <= mark_d;
    end
  end

  assign reached_o  = reached_q;
  assign grew_o     = |grow;
  assign top_open_o = (idx_i == '0) ? open_q : '0;
  assign bot_open_o = (idx_w == cmd_i.rows - 6'd1) ? open_q : '0;

  always_comb begin
    probe_o = '0;
    if (sel) begin
      probe_o.open    = open_q[cmd_i.qcol];
      probe_o.reached = reached_q[cmd_i.qcol];
      probe_o.mark    = mark_q[cmd_i.qcol];
      probe_o.dm      = {dm1_q[cmd_i.qcol], dm0_q[cmd_i.qcol]};
    end
    nb_o       = '0;
    nb_o.up    = is_up && hit[cmd_i.qcol];
    nb_o.down  = is_dn && hit[cmd_i.qcol];
    nb_o.left  = sel && (cmd_i.qcol != '0) && hit[cl];
    nb_o.right = sel && (cmd_i.qcol != '1) && hit[cr];
  end

endmodule

// ----- rtl/core/grid_maze_wavefront_router_unit.sv -----
// Top level of the grid maze wavefront router: control sequencer, config
// registers and the chain of gmw_row_cell rows. Uses gmw_pkg.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): a load transaction writes
// one cell as open or wall; a load with last set starts a solve.
// A read transaction returns the class of one cell on the output channel in
// the next cycle; reads are taken back to back while the receiver keeps up.
// Solve: find entrance and exit, seed the cell below the entrance, flood one
// wavefront step at a time until a step grows nothing, start the trace at the
// exit, then walk the path cell by cell; then the report is registered. The
// flood runs all rows in parallel, one wave per cycle, and the trace walks one
// cell a cycle.
// Output channel (out_valid_o/out_ready_i, out_data_o): one registered slot.
// Every input transaction, loads included, waits for the slot to drain when
// the receiver stalls; a finished solve holds its report until the slot frees.
// Reset clears the grid to walls, the registers to 32 rows and 32 columns,
// and the output slot. APB writes to grid_rows (0x0) and grid_cols (0x4).
module grid_maze_wavefront_router_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gmw_pkg::in_t          in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gmw_pkg::out_t         out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import gmw_pkg::*;

  state_e state_q, state_d;
  logic [DimW-1:0]  rows_q, rows_d, cols_q, cols_d, rows_eff, cols_eff;
  logic             found_q, found_d;
  logic [ColW-1:0]  ent_q, ent_d, exit_q, exit_d;
  logic [RowW-1:0]  cur_r_q, cur_r_d;
  logic [ColW-1:0]  cur_c_q, cur_c_d;
  logic [1:0]       tv_q, tv_d, wmod_q, wmod_d;
  logic [StepW-1:0] cnt_q, cnt_d, steps_q, steps_d;
  logic [1:0]       stat_q, stat_d;
  logic             out_vld_q, out_vld_d;
  out_t             out_q, out_d;

  cell_cmd_t          cmd;
  logic [MaxCols-1:0] reached [MaxRows];
  logic [MaxCols-1:0] top_open [MaxRows];
  logic [MaxCols-1:0] bot_open [MaxRows];
  probe_t             probe [MaxRows];
  nb_t                nb [MaxRows];
  logic [MaxRows-1:0] grew;

  probe_t             pr;
  nb_t                nbs;
  logic [MaxCols-1:0] top_v, bot_v;
  logic               have_in, have_out;
  logic [ColW-1:0]    in_col, out_col;
  logic               in_acc, slot_free, cfg_wr;
  logic [2:0]         rd_class;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_COLS) ? {26'd0, cols_q} : {26'd0, rows_q};

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) rows_d = pwdata[DimW-1:0];
      else cols_d = pwdata[DimW-1:0];
    end
  end

  assign rows_eff = (rows_q < DimMin) ? DimMin : (rows_q > RowsMax) ? RowsMax : rows_q;
  assign cols_eff = (cols_q < DimMin) ? DimMin : (cols_q > ColsMax) ? ColsMax : cols_q;

  // ---------------- row chain ----------------
  for (genvar i = 0; i < MaxRows; i++) begin : g_row
    logic [MaxCols-1:0] up_w, dn_w;
    if (i == 0) begin : g_top
      assign up_w = '0;
    end else begin : g_mid_up
      assign up_w = reached[i-1];
    end
    if (i == MaxRows - 1) begin : g_bot
      assign dn_w = '0;
    end else begin : g_mid_dn
      assign dn_w = reached[i+1];
    end
    gmw_row_cell u_row (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .idx_i        (RowW'(i)),
      .cmd_i        (cmd),
      .up_reached_i (up_w),
      .dn_reached_i (dn_w),
      .reached_o    (reached[i]),
      .top_open_o   (top_open[i]),
      .bot_open_o   (bot_open[i]),
      .probe_o      (probe[i]),
      .nb_o         (nb[i]),
      .grew_o       (grew[i])
    );
  end

  always_comb begin
    pr    = '0;
    nbs   = '0;
    top_v = '0;
    bot_v = '0;
    for (int i = 0; i < MaxRows; i++) begin
      pr    = pr | probe[i];
      nbs   = nbs | nb[i];
      top_v = top_v | top_open[i];
      bot_v = bot_v | bot_open[i];
    end
  end

  // last open column of the entrance and exit rows, within the columns in use
  always_comb begin
    have_in  = 1'b0;
    have_out = 1'b0;
    in_col   = ent_q;
    out_col  = exit_q;
    for (int c = 0; c < MaxCols; c++) begin
      if (DimW'(c) < cols_eff) begin
        if (top_v[c]) begin
          have_in = 1'b1;
          in_col  = ColW'(c);
        end
        if (bot_v[c]) begin
          have_out = 1'b1;
          out_col  = ColW'(c);
        end
      end
    end
  end

  // read reply class
  always_comb begin
    rd_class = CL_WALL;
    if ({1'b0, in_data_i.row} < rows_eff && {1'b0, in_data_i.col} < cols_eff) begin
      if (found_q && in_data_i.row == '0 && in_data_i.col == ent_q) rd_class = CL_ENTRANCE;
      else if (found_q && {1'b0, in_data_i.row} == rows_eff - 6'd1 &&
               in_data_i.col == exit_q) rd_class = CL_EXIT;
      else if (found_q && pr.mark) rd_class = CL_PATH;
      else if (pr.open) rd_class = CL_OPEN;
    end
  end

  // ---------------- sequencer ----------------
  assign slot_free  = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    found_d   = found_q;
    ent_d     = ent_q;
    exit_d    = exit_q;
    cur_r_d   = cur_r_q;
    cur_c_d   = cur_c_q;
    tv_d      = tv_q;
    wmod_d    = wmod_q;
    cnt_d     = cnt_q;
    steps_d   = steps_q;
    stat_d    = stat_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;

    cmd       = '0;
    cmd.rows  = rows_eff;
    cmd.cols  = cols_eff;
    cmd.qrow  = cur_r_q;
    cmd.qcol  = cur_c_q;
    cmd.tgt   = mod3_dec(tv_q);

    if (cfg_wr) found_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd.qrow = in_data_i.row;
        cmd.qcol = in_data_i.col;
        cmd.open = in_data_i.open;
        if (in_acc) begin
          if (in_data_i.kind == KIND_LOAD) begin
            cmd.load = 1'b1;
            found_d  = 1'b0;
            if (in_data_i.last) state_d = S_FIND;
          end else begin
            out_vld_d           = 1'b1;
            out_d               = '0;
            out_d.reply_is_read = 1'b1;
            out_d.cell_class    = rd_class;
          end
        end
      end
      S_FIND: begin
        cmd.clear = 1'b1;
        steps_d   = '0;
        if (have_in) ent_d = in_col;
        if (have_out) exit_d = out_col;
        if (have_in && have_out) begin
          state_d = S_SEED;
        end else begin
          stat_d  = ST_NO_PATH;
          state_d = S_REPORT;
        end
      end
      S_SEED: begin
        cmd.qrow = RowW'(1);
        cmd.qcol = ent_q;
        if (pr.open) begin
          cmd.seed = 1'b1;
          wmod_d   = 2'd2;
          state_d  = S_FLOOD;
        end else begin
          stat_d  = ST_NO_PATH;
          state_d = S_REPORT;
        end
      end
      S_FLOOD: begin
        cmd.flood = 1'b1;
        cmd.tgt   = mod3_inc(wmod_q);
        if (|grew) wmod_d = mod3_inc(wmod_q);
        else state_d = S_TSTART;
      end
      S_TSTART: begin
        cmd.qrow = RowW'(rows_eff - 6'd2);
        cmd.qcol = exit_q;
        if (pr.reached) begin
          cur_r_d = RowW'(rows_eff - 6'd2);
          cur_c_d = exit_q;
          tv_d    = pr.dm;
          cnt_d   = '0;
          state_d = S_TRACE;
        end else begin
          stat_d  = ST_NO_PATH;
          state_d = S_REPORT;
        end
      end
      S_TRACE: begin
        cmd.mark = 1'b1;
        cnt_d    = cnt_q + StepW'(1);
        // the trace ends on reaching the seed cell (row 1, entrance column)
        if (cur_r_q == RowW'(1) && cur_c_q == ent_q) begin
          steps_d = cnt_q + StepW'(1);
          found_d = 1'b1;
          stat_d  = ST_FOUND;
          state_d = S_REPORT;
        end else begin
          tv_d = mod3_dec(tv_q);
          if (nbs.up) cur_r_d = cur_r_q - RowW'(1);
          else if (nbs.left) cur_c_d = cur_c_q - ColW'(1);
          else if (nbs.down) cur_r_d = cur_r_q + RowW'(1);
          else if (nbs.right) cur_c_d = cur_c_q + ColW'(1);
          else begin
            cmd.clr_mark = 1'b1;
            stat_d       = ST_TRACE_ERR;
            state_d      = S_REPORT;
          end
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          out_vld_d    = 1'b1;
          out_d        = '0;
          out_d.status = stat_q;
          out_d.steps  = (stat_q == ST_FOUND) ? steps_q : '0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rows_q    <= RowsMax;
      cols_q    <= ColsMax;
      found_q   <= 1'b0;
      ent_q     <= '0;
      exit_q    <= '0;
      steps_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      found_q   <= found_d;
      ent_q     <= ent_d;
      exit_q    <= exit_d;
      steps_q   <= steps_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    tv_q    <= tv_d;
    wmod_q  <= wmod_d;
    cnt_q   <= cnt_d;
    stat_q  <= stat_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/gmw_checker.sv -----
// Port-level checks for grid_maze_wavefront_router_unit, bound to the top.
// Uses gmw_pkg for the payload types and status codes.
module gmw_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input gmw_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input gmw_pkg::out_t out_data_o
);
  import gmw_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // a read transaction is answered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind == KIND_READ |=>
      out_valid_o && out_data_o.reply_is_read)
    else $error("read transaction without reply");

  // a plain load produces nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind == KIND_LOAD && !in_data_i.last |=>
      !$rose(out_valid_o))
    else $error("load transaction produced a result");

  // steps only carried by a found report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.reply_is_read || out_data_o.status != ST_FOUND) |->
      out_data_o.steps == '0)
    else $error("nonzero steps without a found path");

endmodule

bind grid_maze_wavefront_router_unit gmw_checker u_gmw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
